FILE: rtl/srsf_pkg.sv
// Shared types and constants of the strobed reflective sensor filter.
// Holds the channel payloads, the lane control bundle, phase and LED codes.
// No dependencies; srsf_if, srsf_lane and the top level use this package.
package srsf_pkg;

   localparam int CHANNELS    = 4;
   localparam int FIELD_BITS  = 12;
   localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

   // IIR filter: f = floor((17*d + 3*f_prev) / 20).
   localparam int IIR_NEW_GAIN = 17;
   localparam int IIR_OLD_GAIN = 3;
   localparam int IIR_DIV      = 20;

   // Register stages inside one lane ahead of the result register.
   localparam int LANE_STAGES = 4;

   // Sensors 0 and 1 sit under emitter pair A, the rest under pair B.
   localparam int LIT_A_LANES = 2;

   localparam int PHASE_W = 2;
   localparam logic [PHASE_W-1:0] PHASE_LEAD  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_LIT_A = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_LIT_B = 2'd2;
   localparam logic [PHASE_W-1:0] PHASE_DARK  = 2'd3;

   localparam int LED_A_BIT = 0;
   localparam int LED_B_BIT = 1;
   localparam logic [1:0] LED_OFF    = 2'b00;
   localparam logic [1:0] LED_PAIR_A = 2'b01;
   localparam logic [1:0] LED_PAIR_B = 2'b10;

   typedef struct packed {
      logic [FIELD_BITS-1:0] reading_sensor0;
      logic [FIELD_BITS-1:0] reading_sensor1;
      logic [FIELD_BITS-1:0] reading_sensor2;
      logic [FIELD_BITS-1:0] reading_sensor3;
   } srsf_req_type;

   typedef struct packed {
      logic                  drive_pair_a;
      logic                  drive_pair_b;
      logic                  frame_done;
      logic [FIELD_BITS-1:0] level_sensor0;
      logic [FIELD_BITS-1:0] level_sensor1;
      logic [FIELD_BITS-1:0] level_sensor2;
      logic [FIELD_BITS-1:0] level_sensor3;
   } srsf_rsp_type;

   typedef struct packed {
      logic                   capture;
      logic [LANE_STAGES-1:0] adv;
      logic                   hist_update;
      logic                   level_update;
      logic                   level_pick;
   } srsf_lane_ctl_type;

endpackage

FILE: rtl/srsf_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on srsf_pkg for the payload types.
interface srsf_req_if;
   logic                 valid;
   logic                 ready;
   srsf_pkg::srsf_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface srsf_rsp_if;
   logic                 valid;
   logic                 ready;
   srsf_pkg::srsf_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/srsf_cdiv.sv
// Division by a constant through a registered reciprocal multiplication.
// The quotient is exact for every dividend of IN_W bits. Depends on nothing.
module srsf_cdiv #(
   parameter int IN_W    = 17,
   parameter int OUT_W   = 12,
   parameter int DIVISOR = 20
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [IN_W-1:0]  dividend,
   output logic [OUT_W-1:0] quotient
);

   localparam int DIV_BITS = $clog2(DIVISOR);
   localparam int SHIFT    = IN_W + DIV_BITS;
   localparam int M_W      = IN_W + 1;
   localparam int PROD_W   = IN_W + M_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [M_W-1:0] RECIP = RECIP_FULL[M_W-1:0];

   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= {{M_W{1'b0}}, dividend} * {{IN_W{1'b0}}, RECIP};
      end
   end

   assign quotient = prod_ff[SHIFT +: OUT_W];

endmodule

FILE: rtl/srsf_lane.sv
// One sensor lane: ambient cancellation, IIR filter, moving average, level hold.
// Depends on srsf_pkg and srsf_cdiv.
module srsf_lane #(
   parameter int SAMPLE_BITS = 12,
   parameter int HISTORY_LEN = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  srsf_pkg::srsf_lane_ctl_type     ctl,
   input  logic [SAMPLE_BITS-1:0]          sample,
   output logic [SAMPLE_BITS-1:0]          level
);
   import srsf_pkg::*;

   localparam int NUM_W   = SAMPLE_BITS + $clog2(IIR_DIV);
   localparam int SUM_W   = SAMPLE_BITS + $clog2(HISTORY_LEN);
   localparam int WIN_LEN = HISTORY_LEN - 2;
   localparam int KEEP    = (WIN_LEN > 0) ? WIN_LEN : 1;

   logic [SAMPLE_BITS-1:0] lit_ff;
   logic [SAMPLE_BITS-1:0] dark_ff;
   logic [SAMPLE_BITS-1:0] hist_ff [KEEP];
   logic [SUM_W-1:0]       win_ff;
   logic [SUM_W-1:0]       win_in;
   logic [SUM_W-1:0]       sum_ff;
   logic [SUM_W-1:0]       sum_in;
   logic [SAMPLE_BITS-1:0] hold_ff;
   logic [SAMPLE_BITS-1:0] diff;
   logic [NUM_W-1:0]       num;
   logic [SAMPLE_BITS-1:0] filt;
   logic [SAMPLE_BITS-1:0] avg;

   always_comb begin
      diff = (lit_ff >= dark_ff) ? (lit_ff - dark_ff) : (dark_ff - lit_ff);
      num  = NUM_W'(diff) * NUM_W'(IIR_NEW_GAIN) + NUM_W'(hist_ff[0]) * NUM_W'(IIR_OLD_GAIN);
   end

   srsf_cdiv #(
      .IN_W    (NUM_W),
      .OUT_W   (SAMPLE_BITS),
      .DIVISOR (IIR_DIV)
   ) u_iir_div (
      .clock    (clock),
      .enable   (ctl.adv[1]),
      .dividend (num),
      .quotient (filt)
   );

   // The window holds the sum of the newest WIN_LEN past filter outputs.
   always_comb begin
      sum_in = (SUM_W'(filt) << 1) + win_ff;
      if (WIN_LEN > 0) begin
         win_in = win_ff + SUM_W'(filt) - SUM_W'(hist_ff[KEEP-1]);
      end else begin
         win_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.adv[0]) begin
         dark_ff <= sample;
      end
      if (ctl.adv[2]) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff  <= '0;
         win_ff  <= '0;
         hold_ff <= '0;
         for (int k = 0; k < KEEP; k++) begin
            hist_ff[k] <= '0;
         end
      end else begin
         if (ctl.capture) begin
            lit_ff <= sample;
         end
         if (ctl.hist_update) begin
            for (int k = KEEP - 1; k > 0; k--) begin
               hist_ff[k] <= hist_ff[k-1];
            end
            hist_ff[0] <= filt;
            win_ff     <= win_in;
         end
         if (ctl.level_update) begin
            hold_ff <= avg;
         end
      end
   end

   srsf_cdiv #(
      .IN_W    (SUM_W),
      .OUT_W   (SAMPLE_BITS),
      .DIVISOR (HISTORY_LEN)
   ) u_avg_div (
      .clock    (clock),
      .enable   (ctl.adv[3]),
      .dividend (sum_ff),
      .quotient (avg)
   );

   assign level = ctl.level_pick ? avg : hold_ff;

endmodule

FILE: rtl/strobed_reflective_sensor_filter.sv
// Strobed reflective sensor filter, top level: phase sequencer, LED drive,
// sensor lanes and the result register that merges them.
// Depends on srsf_pkg, srsf_if and srsf_lane.
//
// Each item is one conversion of four reflective sensors, and each item
// returns exactly one result item. A four-item frame lights emitter pair A,
// stores the lit readings of sensors 0 and 1 while pair B is lit, stores
// sensors 2 and 3 with both pairs off, and on the fourth item takes the dark
// readings and updates the averaged levels (frame_done is then 1). The block
// accepts one item per clock cycle when the result side keeps up. An accepted
// item passes through the four lane stages (sample capture, reciprocal
// multiply of the difference and IIR sum for the divide by 20, average sum,
// reciprocal multiply for the divide by HISTORY_LEN) and then the result
// register; the first stage loads at the edge that accepts the item.
// Stalls on the result side back up the stages one at a time, so empty stages
// still take new items. There is no reset sweep.
module strobed_reflective_sensor_filter #(
   parameter int NUM_SENSORS = 4,
   parameter int HISTORY_LEN = 5,
   parameter int SAMPLE_BITS = 12
) (
   input  logic      clock,
   input  logic      reset,
   srsf_req_if.sink   req_chan,
   srsf_rsp_if.source rsp_chan
);
   import srsf_pkg::*;

   localparam int ACTIVE = (NUM_SENSORS < CHANNELS) ? NUM_SENSORS : CHANNELS;

   logic [PHASE_W-1:0]     phase_ff;
   logic [1:0]             led_ff;
   logic [1:0]             led_in;
   logic                   accept;
   logic [LANE_STAGES-1:0] vld_ff;
   logic [LANE_STAGES-1:0] frame_ff;
   logic [1:0]             led_pipe_ff [LANE_STAGES];
   logic [LANE_STAGES-1:0] adv;
   logic                   adv_out;
   logic                   rsp_valid_ff;
   srsf_rsp_type           rsp_payload_ff;
   srsf_rsp_type           rsp_in;
   logic [FIELD_BITS-1:0]  reading [CHANNELS];
   logic [SAMPLE_BITS-1:0] lane_level [CHANNELS];
   logic [FIELD_BITS-1:0]  level_sat [CHANNELS];

   assign reading[0] = req_chan.payload.reading_sensor0;
   assign reading[1] = req_chan.payload.reading_sensor1;
   assign reading[2] = req_chan.payload.reading_sensor2;
   assign reading[3] = req_chan.payload.reading_sensor3;

   // A stage takes new contents when it is empty or its contents move on.
   always_comb begin
      adv_out = !rsp_valid_ff || rsp_chan.ready;
      adv[LANE_STAGES-1] = !vld_ff[LANE_STAGES-1] || adv_out;
      for (int k = LANE_STAGES - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign req_chan.ready = adv[0];
   assign accept         = req_chan.valid && adv[0];

   always_comb begin
      case (phase_ff)
         PHASE_LEAD: begin
            led_in = LED_PAIR_A;
         end
         PHASE_LIT_A: begin
            led_in = LED_PAIR_B;
         end
         PHASE_LIT_B: begin
            led_in = LED_OFF;
         end
         default: begin
            led_in = led_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_LEAD;
         led_ff       <= LED_OFF;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_ff + PHASE_W'(1);
            led_ff   <= led_in;
         end
         if (adv[0]) begin
            vld_ff[0] <= req_chan.valid;
         end
         for (int k = 1; k < LANE_STAGES; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (adv_out) begin
            rsp_valid_ff <= vld_ff[LANE_STAGES-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         frame_ff[0]    <= (phase_ff == PHASE_DARK);
         led_pipe_ff[0] <= led_in;
      end
      for (int k = 1; k < LANE_STAGES; k++) begin
         if (adv[k]) begin
            frame_ff[k]    <= frame_ff[k-1];
            led_pipe_ff[k] <= led_pipe_ff[k-1];
         end
      end
      if (adv_out) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lane
      if (ch < ACTIVE) begin : g_active
         srsf_lane_ctl_type ctl;

         always_comb begin
            ctl.capture = accept &&
               (((phase_ff == PHASE_LIT_A) && (ch < LIT_A_LANES)) ||
                ((phase_ff == PHASE_LIT_B) && (ch >= LIT_A_LANES)));
            ctl.adv          = adv;
            ctl.hist_update  = adv[2] && vld_ff[1] && frame_ff[1];
            ctl.level_update = adv_out && vld_ff[LANE_STAGES-1] && frame_ff[LANE_STAGES-1];
            ctl.level_pick   = frame_ff[LANE_STAGES-1];
         end

         srsf_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .HISTORY_LEN (HISTORY_LEN)
         ) u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctl    (ctl),
            .sample (SAMPLE_BITS'(reading[ch])),
            .level  (lane_level[ch])
         );
      end else begin : g_unused
         assign lane_level[ch] = '0;
      end

      assign level_sat[ch] = (|(lane_level[ch] >> FIELD_BITS)) ? FIELD_MAX
                                                                 : FIELD_BITS'(lane_level[ch]);
   end

   always_comb begin
      rsp_in.drive_pair_a  = led_pipe_ff[LANE_STAGES-1][LED_A_BIT];
      rsp_in.drive_pair_b  = led_pipe_ff[LANE_STAGES-1][LED_B_BIT];
      rsp_in.frame_done    = frame_ff[LANE_STAGES-1];
      rsp_in.level_sensor0 = level_sat[0];
      rsp_in.level_sensor1 = level_sat[1];
      rsp_in.level_sensor2 = level_sat[2];
      rsp_in.level_sensor3 = level_sat[3];
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule
